### sv/cga_pkg.sv
// shared types and constants of the csr graph adjacency store
// no dependencies; imported by cga_csr, the top level and the checker
package cga_pkg;

    localparam int unsigned MaxVertices = 256;
    localparam int unsigned MaxEdges    = 1024;
    localparam int unsigned PairDepth   = 2 * MaxEdges;
    localparam int unsigned OffDepth    = MaxVertices + 1;

    localparam logic [2:0] KIND_ADD   = 3'd0;
    localparam logic [2:0] KIND_BUILD = 3'd1;
    localparam logic [2:0] KIND_QUERY = 3'd2;
    localparam logic [2:0] KIND_FETCH = 3'd3;
    localparam logic [2:0] KIND_CWR   = 3'd4;
    localparam logic [2:0] KIND_CRD   = 3'd5;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         source_vertex;
        logic [7:0]         target_vertex;
        logic [10:0]        position;
        logic               reverse_direction;
        logic signed [31:0] color_value;
    } t_in;

    typedef struct packed {
        logic               found;
        logic [7:0]         neighbour_id;
        logic [11:0]        degree;
        logic signed [31:0] color_out;
        logic [10:0]        edge_total;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic [8:0] vertex_total;
        logic       directed;
        logic       clear;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ADD2,
        ST_S_NEXT, ST_S_KEY, ST_S_CMP, ST_S_PLACE,
        ST_OF_INIT, ST_OF_RD, ST_OF_GET, ST_OF_CMP, ST_OF_TAIL,
        ST_RV_VTX, ST_RV_SCAN,
        ST_Q_B, ST_Q_E, ST_Q_SCAN, ST_Q_CHK,
        ST_F_RD, ST_F_OUT, ST_C_OUT
    } t_state;

endpackage

### sv/cga_ram.sv
// simple dual-port ram: one write port, one read port, registered read data
// depends on nothing
module cga_ram #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_wa,
    input  logic [W-1:0]         i_wd,
    input  logic [$clog2(D)-1:0] i_ra,
    output logic [W-1:0]         o_rd
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_rd <= r_mem[i_ra];
    end

    assign o_rd = r_rd;
endmodule

### sv/cga_csr.sv
// apb configuration registers: vertex total (clamped) and directed mode
// depends on cga_pkg
module cga_csr
    import cga_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    logic [8:0] r_vt, n_vt;
    logic       r_dir;
    logic       wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_vt = pwdata[8:0];
        if (n_vt == 9'd0) begin
            n_vt = 9'd1;
        end else if (n_vt > 9'(MaxVertices)) begin
            n_vt = 9'(MaxVertices);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt  <= 9'(MaxVertices);
            r_dir <= 1'b0;
        end else if (wr) begin
            if (paddr[2]) begin
                r_dir <= pwdata[0];
            end else begin
                r_vt <= n_vt;
            end
        end
    end

    assign prdata = paddr[2] ? {31'd0, r_dir} : {23'd0, r_vt};

    always_comb begin
        o_cfg.vertex_total = r_vt;
        o_cfg.directed     = r_dir;
        o_cfg.clear        = wr;
    end
endmodule

### sv/csr_graph_adjacency_store.sv
// top level of the csr graph adjacency store: command sequencer and memories
// depends on cga_pkg, cga_ram, cga_csr
//
// One item at a time: busy is high while an item is worked on, and the result
// is shown for exactly one cycle with o_done high; the receiver cannot stall,
// so it must take every result in that cycle. An add in undirected mode also
// stores the mirrored edge; an edge query scans the neighbours of the source
// one by one. A build runs an insertion sort over the pair ram, then an offset
// pass, and in directed mode a reversed pass that scans the pair ram once for
// each vertex up to the vertex total. The single read port of the pair ram
// paces the build, the edge query and the neighbour fetch.
module csr_graph_adjacency_store
    import cga_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_in         i_cmd,
    output logic        busy,
    output logic        o_done,
    output t_out        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg cfg;

    t_state      r_state, n_state;
    t_in         r_item, n_item;
    logic [11:0] r_count, n_count;
    logic [10:0] r_added, n_added;
    logic        r_built, n_built;
    logic [11:0] r_i, n_i;
    logic [11:0] r_j, n_j;
    logic [15:0] r_key, n_key;
    logic [8:0]  r_v, n_v;
    logic [10:0] r_p, n_p;
    logic [11:0] r_b, n_b;
    logic [11:0] r_e, n_e;
    logic        r_use_rev, n_use_rev;
    logic        r_done, n_done;
    t_out        r_res, n_res;

    logic        pair_we;
    logic [10:0] pair_wa, pair_ra;
    logic [15:0] pair_wd, pair_rd;
    logic        fof_we, rof_we;
    logic [8:0]  off_wa, off_ra;
    logic [11:0] fof_wd, fof_rd;
    logic [10:0] rof_wd, rof_rd;
    logic        rev_we;
    logic [9:0]  rev_wa, rev_ra;
    logic [7:0]  rev_wd, rev_rd;
    logic        col_we;
    logic [7:0]  col_wa, col_ra;
    logic [31:0] col_wd, col_rd;

    logic        s_oor, t_oor;
    logic [11:0] off_sel, deg, fpos;

    cga_csr u_csr (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    cga_ram #(.W(16), .D(PairDepth)) u_pair (
        .i_clk, .i_we(pair_we), .i_wa(pair_wa), .i_wd(pair_wd),
        .i_ra(pair_ra), .o_rd(pair_rd)
    );
    cga_ram #(.W(12), .D(OffDepth)) u_fof (
        .i_clk, .i_we(fof_we), .i_wa(off_wa), .i_wd(fof_wd),
        .i_ra(off_ra), .o_rd(fof_rd)
    );
    cga_ram #(.W(11), .D(OffDepth)) u_rof (
        .i_clk, .i_we(rof_we), .i_wa(off_wa), .i_wd(rof_wd),
        .i_ra(off_ra), .o_rd(rof_rd)
    );
    cga_ram #(.W(8), .D(MaxEdges)) u_rev (
        .i_clk, .i_we(rev_we), .i_wa(rev_wa), .i_wd(rev_wd),
        .i_ra(rev_ra), .o_rd(rev_rd)
    );
    cga_ram #(.W(32), .D(MaxVertices)) u_col (
        .i_clk, .i_we(col_we), .i_wa(col_wa), .i_wd(col_wd),
        .i_ra(col_ra), .o_rd(col_rd)
    );

    assign s_oor   = {1'b0, i_cmd.source_vertex} >= cfg.vertex_total;
    assign t_oor   = {1'b0, i_cmd.target_vertex} >= cfg.vertex_total;
    assign off_sel = r_use_rev ? {1'b0, rof_rd} : fof_rd;
    assign deg     = r_e - r_b;
    assign fpos    = r_b + {1'b0, r_item.position};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_added <= '0;
            r_built <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_added <= n_added;
            r_built <= n_built;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_i       <= n_i;
        r_j       <= n_j;
        r_key     <= n_key;
        r_v       <= n_v;
        r_p       <= n_p;
        r_b       <= n_b;
        r_e       <= n_e;
        r_use_rev <= n_use_rev;
        r_res     <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_count   = r_count;
        n_added   = r_added;
        n_built   = r_built;
        n_i       = r_i;
        n_j       = r_j;
        n_key     = r_key;
        n_v       = r_v;
        n_p       = r_p;
        n_b       = r_b;
        n_e       = r_e;
        n_use_rev = r_use_rev;
        n_done    = 1'b0;
        n_res     = r_res;

        pair_we = 1'b0;
        pair_wa = r_count[10:0];
        pair_wd = r_key;
        pair_ra = r_i[10:0];
        fof_we  = 1'b0;
        rof_we  = 1'b0;
        off_wa  = r_v;
        fof_wd  = r_i;
        rof_wd  = r_p;
        off_ra  = {1'b0, r_item.source_vertex};
        rev_we  = 1'b0;
        rev_wa  = r_p[9:0];
        rev_wd  = pair_rd[15:8];
        rev_ra  = fpos[9:0];
        col_we  = 1'b0;
        col_wa  = i_cmd.source_vertex;
        col_wd  = i_cmd.color_value;
        col_ra  = i_cmd.source_vertex;

        unique case (r_state)
            ST_IDLE: begin
                if (cfg.clear) begin
                    n_count = '0;
                    n_added = '0;
                    n_built = 1'b0;
                end
                if (start) begin
                    n_item = i_cmd;
                    n_res  = '0;
                    n_done = 1'b1;
                    off_ra = {1'b0, i_cmd.source_vertex};
                    unique case (i_cmd.kind)
                        KIND_ADD: begin
                            if (s_oor || t_oor) begin
                                n_res.status = STAT_RANGE;
                            end else if (r_added >= 11'(MaxEdges)) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                pair_we = 1'b1;
                                pair_wd = {i_cmd.source_vertex, i_cmd.target_vertex};
                                n_count = r_count + 12'd1;
                                n_added = r_added + 11'd1;
                                n_built = 1'b0;
                                if (!cfg.directed) begin
                                    n_done  = 1'b0;
                                    n_state = ST_ADD2;
                                end
                            end
                        end
                        KIND_BUILD: begin
                            n_done  = 1'b0;
                            n_i     = 12'd1;
                            n_state = ST_S_NEXT;
                        end
                        KIND_QUERY: begin
                            if (!r_built || s_oor || t_oor) begin
                                n_res.status = STAT_RANGE;
                            end else begin
                                n_done    = 1'b0;
                                n_use_rev = 1'b0;
                                n_state   = ST_Q_B;
                            end
                        end
                        KIND_FETCH: begin
                            if (!r_built || s_oor) begin
                                n_res.status = STAT_RANGE;
                            end else begin
                                n_done    = 1'b0;
                                n_use_rev = i_cmd.reverse_direction && cfg.directed;
                                n_state   = ST_Q_B;
                            end
                        end
                        KIND_CWR: begin
                            if (s_oor) begin
                                n_res.status = STAT_RANGE;
                            end else begin
                                col_we = 1'b1;
                            end
                        end
                        KIND_CRD: begin
                            if (s_oor) begin
                                n_res.status = STAT_RANGE;
                            end else begin
                                n_done  = 1'b0;
                                n_state = ST_C_OUT;
                            end
                        end
                        default: begin
                            n_res.status = STAT_RANGE;
                        end
                    endcase
                end
            end
            ST_ADD2: begin
                // mirrored copy of the edge
                pair_we = 1'b1;
                pair_wd = {r_item.target_vertex, r_item.source_vertex};
                n_count = r_count + 12'd1;
                n_res   = '0;
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_S_NEXT: begin
                if (r_i >= r_count) begin
                    n_state = ST_OF_INIT;
                end else begin
                    pair_ra = r_i[10:0];
                    n_state = ST_S_KEY;
                end
            end
            ST_S_KEY: begin
                n_key   = pair_rd;
                n_j     = r_i;
                pair_ra = 11'(r_i - 12'd1);
                n_state = ST_S_CMP;
            end
            ST_S_CMP: begin
                // pair_rd holds entry j-1; shift it up while larger than key
                if (pair_rd > r_key) begin
                    pair_we = 1'b1;
                    pair_wa = r_j[10:0];
                    pair_wd = pair_rd;
                    n_j     = r_j - 12'd1;
                    if (r_j > 12'd1) begin
                        pair_ra = 11'(r_j - 12'd2);
                    end else begin
                        n_state = ST_S_PLACE;
                    end
                end else begin
                    n_state = ST_S_PLACE;
                end
            end
            ST_S_PLACE: begin
                pair_we = 1'b1;
                pair_wa = r_j[10:0];
                pair_wd = r_key;
                n_i     = r_i + 12'd1;
                n_state = ST_S_NEXT;
            end
            ST_OF_INIT: begin
                n_i     = '0;
                n_v     = '0;
                n_state = (r_count == 12'd0) ? ST_OF_TAIL : ST_OF_RD;
            end
            ST_OF_RD: begin
                pair_ra = r_i[10:0];
                n_state = ST_OF_GET;
            end
            ST_OF_GET: begin
                n_key   = pair_rd;
                n_state = ST_OF_CMP;
            end
            ST_OF_CMP: begin
                // offset of v is the index of the first entry with source >= v
                if (r_v <= {1'b0, r_key[15:8]}) begin
                    fof_we = 1'b1;
                    fof_wd = r_i;
                    n_v    = r_v + 9'd1;
                end else begin
                    n_i     = r_i + 12'd1;
                    n_state = ((r_i + 12'd1) >= r_count) ? ST_OF_TAIL : ST_OF_RD;
                end
            end
            ST_OF_TAIL: begin
                fof_we = 1'b1;
                fof_wd = r_count;
                if (r_v == cfg.vertex_total) begin
                    if (cfg.directed) begin
                        n_v     = '0;
                        n_p     = '0;
                        n_state = ST_RV_VTX;
                    end else begin
                        n_built = 1'b1;
                        n_res   = '0;
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_v = r_v + 9'd1;
                end
            end
            ST_RV_VTX: begin
                rof_we = 1'b1;
                rof_wd = r_p;
                if (r_v == cfg.vertex_total) begin
                    n_built = 1'b1;
                    n_res   = '0;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_count == 12'd0) begin
                    n_v = r_v + 9'd1;
                end else begin
                    pair_ra = '0;
                    n_i     = 12'd1;
                    n_state = ST_RV_SCAN;
                end
            end
            ST_RV_SCAN: begin
                // collect the sources of every entry whose target is v
                if (pair_rd[7:0] == r_v[7:0]) begin
                    rev_we = 1'b1;
                    n_p    = r_p + 11'd1;
                end
                if (r_i < r_count) begin
                    pair_ra = r_i[10:0];
                    n_i     = r_i + 12'd1;
                end else begin
                    n_v     = r_v + 9'd1;
                    n_state = ST_RV_VTX;
                end
            end
            ST_Q_B: begin
                n_b     = off_sel;
                off_ra  = {1'b0, r_item.source_vertex} + 9'd1;
                n_state = ST_Q_E;
            end
            ST_Q_E: begin
                n_e     = off_sel;
                n_i     = r_b;
                n_state = (r_item.kind == KIND_QUERY) ? ST_Q_SCAN : ST_F_RD;
            end
            ST_Q_SCAN: begin
                if (r_i >= r_e) begin
                    n_res        = '0;
                    n_res.degree = deg;
                    n_done       = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    pair_ra = r_i[10:0];
                    n_i     = r_i + 12'd1;
                    n_state = ST_Q_CHK;
                end
            end
            ST_Q_CHK: begin
                if (pair_rd[7:0] == r_item.target_vertex) begin
                    n_res        = '0;
                    n_res.found  = 1'b1;
                    n_res.degree = deg;
                    n_done       = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    n_state = ST_Q_SCAN;
                end
            end
            ST_F_RD: begin
                if ({1'b0, r_item.position} < deg) begin
                    pair_ra = fpos[10:0];
                    n_state = ST_F_OUT;
                end else begin
                    n_res        = '0;
                    n_res.degree = deg;
                    n_res.status = STAT_RANGE;
                    n_done       = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_F_OUT: begin
                n_res              = '0;
                n_res.found        = 1'b1;
                n_res.degree       = deg;
                n_res.neighbour_id = r_use_rev ? rev_rd : pair_rd[7:0];
                n_done             = 1'b1;
                n_state            = ST_IDLE;
            end
            ST_C_OUT: begin
                n_res           = '0;
                n_res.color_out = col_rd;
                n_done          = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (n_done) begin
            n_res.edge_total = n_added;
        end
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

### sv/cga_checker.sv
// port-level checker for the csr graph adjacency store, bound to the top level
// depends on cga_pkg and csr_graph_adjacency_store
module cga_checker
    import cga_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input t_out        o_res
);
    // an accepted item is either in work or answered in the next cycle
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted item neither busy nor answered");

    // a result follows an accepted item or a busy cycle
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start && !busy) || $past(busy)))
        else $error("result without an item");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.found) |-> (o_res.status == STAT_OK))
        else $error("found with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.status <= STAT_RANGE))
        else $error("undefined status code");
endmodule

bind csr_graph_adjacency_store cga_checker u_cga_checker (.*);
